/* rtl/drs_pkg.sv */
// Package for the disk request scheduler: codes, defaults, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package drs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int BLOCK_BITS_DEF  = 16;
    localparam int TAG_BITS_DEF    = 8;

    localparam int SEEK_W     = 18;
    localparam int TOTAL_W    = 48;
    localparam int STATUS_W   = 2;
    localparam int POLICY_W   = 2;
    localparam int CFG_ADDR_W = 1;

    localparam logic [SEEK_W-1:0]  SEEK_MAX         = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX        = '1;
    localparam logic [31:0]        LAST_BLOCK_RESET = 32'd65535;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_POLICY     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAST_BLOCK = 1'd1;

    localparam logic [POLICY_W-1:0] POL_FCFS  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SSTF  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_CSCAN = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ,
        S_SCAN,
        S_SCAN_END,
        S_CHARGE,
        S_TOTAL,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                load_in;
        logic                scan_issue;
        logic                charge;
        logic                total_upd;
        logic                shift_issue;
        logic                shift_end;
        logic                enq_write;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_dispatch;
        logic full;
        logic empty;
        logic scan_last;
        logic shift_more;
    } t_dp_sts;

endpackage

/* rtl/drs_ctrl.sv */
// Controller FSM of the disk request scheduler: sequences decode, scan,
// charge, close-up and result hand-off. Depends on drs_pkg.
module drs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  drs_pkg::t_dp_sts  i_sts,
    output drs_pkg::t_dp_cmd  o_cmd
);
    import drs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.cmd_dispatch) begin
                    n_state = S_ENQ;
                end else if (i_sts.empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_EMPTY;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ENQ: begin
                o_cmd.set_status = 1'b1;
                if (i_sts.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.status    = ST_ENQUEUED;
                    o_cmd.enq_write = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_CHARGE;
            end
            S_CHARGE: begin
                o_cmd.charge     = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_DISPATCHED;
                n_state          = S_TOTAL;
            end
            S_TOTAL: begin
                o_cmd.total_upd = 1'b1;
                n_state         = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.shift_issue = 1'b1;
                end else begin
                    o_cmd.shift_end = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/drs_dp.sv */
// Datapath of the disk request scheduler: request memory, policy scan,
// seek charge, saturating total, close-up and result register. Depends on drs_pkg.
module drs_dp #(
    parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
    parameter int BLOCK_BITS  = drs_pkg::BLOCK_BITS_DEF,
    parameter int TAG_BITS    = drs_pkg::TAG_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  drs_pkg::t_dp_cmd                 i_cmd,
    output drs_pkg::t_dp_sts                 o_sts,
    input  logic                             i_cfg_we,
    input  logic [drs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [BLOCK_BITS-1:0]            i_cfg_wdata,
    input  logic                             i_in_command,
    input  logic [BLOCK_BITS-1:0]            i_in_block,
    input  logic                             i_in_write,
    input  logic [TAG_BITS-1:0]              i_in_tag,
    output logic [drs_pkg::STATUS_W-1:0]     o_status,
    output logic [BLOCK_BITS-1:0]            o_block,
    output logic                             o_write,
    output logic [TAG_BITS-1:0]              o_tag,
    output logic [drs_pkg::SEEK_W-1:0]       o_seek,
    output logic [drs_pkg::TOTAL_W-1:0]      o_total
);
    import drs_pkg::*;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DIST_W = BLOCK_BITS + 2;
    localparam int ENT_W  = BLOCK_BITS + 1 + TAG_BITS;
    localparam int CMP_W  = (DIST_W > SEEK_W) ? DIST_W : SEEK_W;
    localparam int LAST_W = (BLOCK_BITS < 16) ? BLOCK_BITS : 16;

    // entry layout: {tag, write, block}
    logic [ENT_W-1:0] mem [QUEUE_DEPTH];

    logic [POLICY_W-1:0]   r_policy;
    logic [BLOCK_BITS-1:0] r_last;
    logic [CNT_W-1:0]      r_count;
    logic [BLOCK_BITS-1:0] r_head;
    logic [TOTAL_W-1:0]    r_total;

    logic                  r_cmd;
    logic [ENT_W-1:0]      r_in_ent;

    logic [IDX_W-1:0]      r_sidx;
    logic [ENT_W-1:0]      r_rd;
    logic                  r_eval_vld;
    logic [IDX_W-1:0]      r_eval_idx;
    logic                  r_wpend;
    logic [IDX_W-1:0]      r_wdst;

    logic                  r_have;
    logic [ENT_W-1:0]      r_best_ent;
    logic [IDX_W-1:0]      r_best_idx;
    logic [BLOCK_BITS-1:0] r_best_d;
    logic [ENT_W-1:0]      r_low_ent;
    logic [IDX_W-1:0]      r_low_idx;

    logic [DIST_W-1:0]     r_dist;
    logic [STATUS_W-1:0]   r_res_status;
    logic [ENT_W-1:0]      r_res_ent;
    logic [SEEK_W-1:0]     r_res_seek;

    logic [STATUS_W-1:0]   r_o_status;
    logic [ENT_W-1:0]      r_o_ent;
    logic [SEEK_W-1:0]     r_o_seek;
    logic [TOTAL_W-1:0]    r_o_total;

    // scan evaluation
    logic [BLOCK_BITS-1:0] e_blk;
    logic                  e_first, e_up, e_cand, e_take_best, e_take_low;
    logic [BLOCK_BITS-1:0] e_diff_up, e_diff_dn, e_cd;

    // charge
    logic [ENT_W-1:0]      sel_ent;
    logic [IDX_W-1:0]      sel_idx;
    logic [BLOCK_BITS-1:0] sel_blk, wrap_up, near_d;
    logic [DIST_W-1:0]     wrap_d, charge_d;

    // close-up and memory ports
    logic [CNT_W-1:0]      sidx_inc;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [ENT_W-1:0]      mem_wd;

    logic [TOTAL_W:0]      total_sum;
    logic [SEEK_W-1:0]     seek_sat;

    assign e_blk     = r_rd[BLOCK_BITS-1:0];
    assign e_first   = (r_eval_idx == '0);
    assign e_up      = (e_blk >= r_head);
    assign e_diff_up = e_blk - r_head;
    assign e_diff_dn = r_head - e_blk;

    always_comb begin
        case (r_policy)
            POL_SSTF: begin
                e_cand = 1'b1;
                e_cd   = e_up ? e_diff_up : e_diff_dn;
            end
            POL_CSCAN: begin
                e_cand = e_up;
                e_cd   = e_diff_up;
            end
            default: begin
                e_cand = e_first;
                e_cd   = '0;
            end
        endcase
    end

    assign e_take_best = r_eval_vld && e_cand && (!r_have || (e_cd < r_best_d));
    assign e_take_low  = r_eval_vld && (e_first || (e_blk < r_low_ent[BLOCK_BITS-1:0]));

    assign sel_ent  = r_have ? r_best_ent : r_low_ent;
    assign sel_idx  = r_have ? r_best_idx : r_low_idx;
    assign sel_blk  = sel_ent[BLOCK_BITS-1:0];
    assign wrap_up  = (r_last >= r_head) ? (r_last - r_head) : '0;
    assign wrap_d   = DIST_W'(wrap_up) + DIST_W'(r_last) + DIST_W'(1) + DIST_W'(sel_blk);
    assign near_d   = (sel_blk >= r_head) ? (sel_blk - r_head) : (r_head - sel_blk);
    assign charge_d = r_have ? DIST_W'(near_d) : wrap_d;

    assign total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(r_dist);
    assign seek_sat  = (CMP_W'(r_dist) > CMP_W'(SEEK_MAX)) ? SEEK_MAX : SEEK_W'(r_dist);

    assign sidx_inc = CNT_W'(r_sidx) + CNT_W'(1);
    assign rd_addr  = i_cmd.scan_issue ? r_sidx : sidx_inc[IDX_W-1:0];
    assign mem_we   = r_wpend || i_cmd.enq_write;
    assign mem_wa   = r_wpend ? r_wdst : r_count[IDX_W-1:0];
    assign mem_wd   = r_wpend ? r_rd : r_in_ent;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= POL_FCFS;
            r_last     <= BLOCK_BITS'(LAST_BLOCK_RESET);
            r_count    <= '0;
            r_head     <= '0;
            r_total    <= '0;
            r_eval_vld <= 1'b0;
            r_wpend    <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_POLICY:     r_policy <= i_cfg_wdata[POLICY_W-1:0];
                    CFG_LAST_BLOCK: r_last   <= BLOCK_BITS'(i_cfg_wdata[LAST_W-1:0]);
                    default:        r_policy <= r_policy;
                endcase
            end
            r_eval_vld <= i_cmd.scan_issue;
            r_wpend    <= i_cmd.shift_issue;
            if (i_cmd.load_in) begin
                r_have <= 1'b0;
            end else if (e_take_best) begin
                r_have <= 1'b1;
            end
            if (i_cmd.enq_write) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.shift_end) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.charge) begin
                r_head <= sel_blk;
            end
            if (i_cmd.total_upd) begin
                r_total <= (total_sum >= (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : total_sum[TOTAL_W-1:0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd      <= i_in_command;
            r_in_ent   <= {i_in_tag, i_in_write, i_in_block};
            r_res_ent  <= '0;
            r_res_seek <= '0;
        end
        if (i_cmd.load_in) begin
            r_sidx <= '0;
        end else if (i_cmd.scan_issue) begin
            r_sidx <= r_sidx + IDX_W'(1);
        end else if (i_cmd.charge) begin
            r_sidx <= sel_idx;
        end else if (i_cmd.shift_issue) begin
            r_sidx <= sidx_inc[IDX_W-1:0];
        end
        r_eval_idx <= r_sidx;
        r_wdst     <= r_sidx;
        if (e_take_best) begin
            r_best_ent <= r_rd;
            r_best_idx <= r_eval_idx;
            r_best_d   <= e_cd;
        end
        if (e_take_low) begin
            r_low_ent <= r_rd;
            r_low_idx <= r_eval_idx;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.charge) begin
            r_res_ent <= sel_ent;
            r_dist    <= charge_d;
        end
        if (i_cmd.total_upd) begin
            r_res_seek <= seek_sat;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_ent    <= r_res_ent;
            r_o_seek   <= r_res_seek;
            r_o_total  <= r_total;
        end
    end

    assign o_sts.cmd_dispatch = (r_cmd == CMD_DISPATCH);
    assign o_sts.full         = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_sts.empty        = (r_count == '0);
    assign o_sts.scan_last    = (CNT_W'(r_sidx) == (r_count - CNT_W'(1)));
    assign o_sts.shift_more   = (sidx_inc < r_count);

    assign o_status = r_o_status;
    assign o_block  = r_o_ent[BLOCK_BITS-1:0];
    assign o_write  = r_o_ent[BLOCK_BITS];
    assign o_tag    = r_o_ent[ENT_W-1:BLOCK_BITS+1];
    assign o_seek   = r_o_seek;
    assign o_total  = r_o_total;

endmodule

/* rtl/disk_request_scheduler_core.sv */
// Disk request scheduler, top level: stream ports, word packing and checks.
// Depends on drs_pkg, drs_ctrl and drs_dp.
//
// Use: each input word is a command (tuser) with a request (tdata). Enqueue
// appends the request; dispatch picks one by the policy register (FCFS, SSTF,
// C-SCAN, ties to the oldest), moves the head there and charges the seek.
// Every input word gives exactly one output word: status in tuser, and the
// dispatched request, seek distance and running total in tdata.
// A dispatch scans the queue with one request-memory read per cycle, then
// charges the seek and updates the total, then closes up the queue behind
// the picked entry with one read and write per cycle.
// One word is processed at a time; the next is accepted once the last
// result is in the output register, even if that word is not yet taken.
// Reset: queue empty, head and total zero, policy FCFS, last block all ones.
// A stalled receiver holds the output word; the following result waits
// inside until the register frees, and no input is accepted meanwhile.
// Configuration writes are taken at any time but are meant for idle periods.
module disk_request_scheduler_core #(
    parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
    parameter int BLOCK_BITS  = drs_pkg::BLOCK_BITS_DEF,
    parameter int TAG_BITS    = drs_pkg::TAG_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [drs_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [BLOCK_BITS-1:0]                 i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // block, is_write, tag
    input  logic [((BLOCK_BITS+1+TAG_BITS+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_block, out_is_write, out_tag, seek_distance, total_walked
    output logic [((BLOCK_BITS+1+TAG_BITS+drs_pkg::SEEK_W+drs_pkg::TOTAL_W+7)/8)*8-1:0]
                                                  m_axis_tdata,
    // status
    output logic [drs_pkg::STATUS_W-1:0]          m_axis_tuser
);
    import drs_pkg::*;

    localparam int OUT_W   = BLOCK_BITS + 1 + TAG_BITS + SEEK_W + TOTAL_W;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    logic [BLOCK_BITS-1:0] w_block;
    logic                  w_write;
    logic [TAG_BITS-1:0]   w_tag;
    logic [SEEK_W-1:0]     w_seek;
    logic [TOTAL_W-1:0]    w_total;

    drs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    drs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BLOCK_BITS  (BLOCK_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_command (s_axis_tuser),
        .i_in_block   (s_axis_tdata[BLOCK_BITS-1:0]),
        .i_in_write   (s_axis_tdata[BLOCK_BITS]),
        .i_in_tag     (s_axis_tdata[BLOCK_BITS+TAG_BITS:BLOCK_BITS+1]),
        .o_status     (m_axis_tuser),
        .o_block      (w_block),
        .o_write      (w_write),
        .o_tag        (w_tag),
        .o_seek       (w_seek),
        .o_total      (w_total)
    );

    assign m_axis_tdata = OUT_PAD'({w_total, w_seek, w_tag, w_write, w_block});

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.enq_write |-> !w_sts.full)
        else $error("enqueue write with queue full");

    a_no_scan_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_issue |-> !w_sts.empty)
        else $error("scan issued on empty queue");

    a_out_reg_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a word still waiting");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while busy");

endmodule

/* verif/drs_reply_checker.sv */
// Reply checker for disk_request_scheduler_core: keeps its own copy of the request
// queue, head position, seek total and registers, and checks every output word.
// Depends on drs_pkg.
module drs_reply_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [drs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [15:0]                      i_cfg_wdata,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    // block, is_write, tag
    input  logic [31:0]                      i_req_data,
    // command
    input  logic                             i_req_cmd,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_ready,
    // out_block, out_is_write, out_tag, seek_distance, total_walked
    input  logic [95:0]                      i_rsp_data,
    // status
    input  logic [drs_pkg::STATUS_W-1:0]     i_rsp_status,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    import drs_pkg::*;

    localparam int DEPTH  = QUEUE_DEPTH_DEF;
    localparam int OW_BIT = 16;
    localparam int OT_LSB = 17;
    localparam int SK_LSB = 25;
    localparam int TW_LSB = 43;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [15:0]         blk;
        logic                wr;
        logic [7:0]          tag;
        logic [SEEK_W-1:0]   seek;
        logic [TOTAL_W-1:0]  total;
    } reply_t;

    logic [15:0]         queue_blk [DEPTH];
    logic                queue_wr  [DEPTH];
    logic [7:0]          queue_tag [DEPTH];
    int                  queued;
    logic [15:0]         head;
    logic [TOTAL_W-1:0]  walked;
    logic [POLICY_W-1:0] policy;
    logic [15:0]         last_blk;
    reply_t              awaited [$];
    int                  mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [63:0] span(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? 64'(a - b) : 64'(b - a);
    endfunction

    task automatic serve_command(input logic cmd, input logic [15:0] b, input logic w,
                                 input logic [7:0] t, output reply_t r);
        int          pick;
        int          low;
        int          i;
        logic        found;
        logic        wrapped;
        logic [63:0] d;
        logic [63:0] best;
        logic [63:0] up;
        r = '0;
        if (cmd == CMD_ENQUEUE) begin
            if (queued >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                queue_blk[queued] = b;
                queue_wr[queued]  = w;
                queue_tag[queued] = t;
                queued++;
                r.status = ST_ENQUEUED;
            end
        end else if (queued == 0) begin
            r.status = ST_EMPTY;
        end else begin
            pick    = 0;
            wrapped = 1'b0;
            if (policy == POL_SSTF) begin
                best = span(queue_blk[0], head);
                for (i = 1; i < queued; i++) begin
                    d = span(queue_blk[i], head);
                    if (d < best) begin
                        best = d;
                        pick = i;
                    end
                end
            end else if (policy == POL_CSCAN) begin
                found = 1'b0;
                low   = 0;
                best  = '0;
                for (i = 0; i < queued; i++) begin
                    if (queue_blk[i] >= head) begin
                        d = 64'(queue_blk[i] - head);
                        if (!found || d < best) begin
                            found = 1'b1;
                            best  = d;
                            pick  = i;
                        end
                    end
                    if (queue_blk[i] < queue_blk[low])
                        low = i;
                end
                wrapped = !found;
                if (wrapped)
                    pick = low;
            end
            r.blk = queue_blk[pick];
            r.wr  = queue_wr[pick];
            r.tag = queue_tag[pick];
            if (wrapped) begin
                // head past the last block: the run up to the end counts as nothing
                up = (last_blk >= head) ? 64'(last_blk - head) : 64'd0;
                d  = up + 64'(last_blk) + 64'd1 + 64'(r.blk);
            end else begin
                d = span(r.blk, head);
            end
            r.seek = (d > 64'(SEEK_MAX)) ? SEEK_MAX : d[SEEK_W-1:0];
            if (d >= 64'(TOTAL_MAX) - 64'(walked))
                walked = TOTAL_MAX;
            else
                walked = walked + d[TOTAL_W-1:0];
            head = r.blk;
            for (i = pick; i < queued - 1; i++) begin
                queue_blk[i] = queue_blk[i + 1];
                queue_wr[i]  = queue_wr[i + 1];
                queue_tag[i] = queue_tag[i + 1];
            end
            queued--;
            r.status = ST_DISPATCHED;
        end
        r.total = walked;
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 40)
            $display("%0t: %s is %0h, expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        reply_t fresh;
        reply_t oldest;
        reply_t seen;
        if (!i_rst_n) begin
            queued   = 0;
            head     = '0;
            walked   = '0;
            policy   = POL_FCFS;
            last_blk = LAST_BLOCK_RESET[15:0];
            awaited.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_POLICY)
                    policy = i_cfg_wdata[POLICY_W-1:0];
                else if (i_cfg_addr == CFG_LAST_BLOCK)
                    last_blk = i_cfg_wdata;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                seen.status = i_rsp_status;
                seen.blk    = i_rsp_data[15:0];
                seen.wr     = i_rsp_data[OW_BIT];
                seen.tag    = i_rsp_data[OT_LSB +: 8];
                seen.seek   = i_rsp_data[SK_LSB +: SEEK_W];
                seen.total  = i_rsp_data[TW_LSB +: TOTAL_W];
                if (awaited.size() == 0) begin
                    report_mismatch("unexpected word, status", 64'(seen.status), 64'd0);
                end else begin
                    oldest = awaited.pop_front();
                    if (seen.status != oldest.status)
                        report_mismatch("status", 64'(seen.status), 64'(oldest.status));
                    if (seen.blk != oldest.blk)
                        report_mismatch("out_block", 64'(seen.blk), 64'(oldest.blk));
                    if (seen.wr != oldest.wr)
                        report_mismatch("out_is_write", 64'(seen.wr), 64'(oldest.wr));
                    if (seen.tag != oldest.tag)
                        report_mismatch("out_tag", 64'(seen.tag), 64'(oldest.tag));
                    if (seen.seek != oldest.seek)
                        report_mismatch("seek_distance", 64'(seen.seek), 64'(oldest.seek));
                    if (seen.total != oldest.total)
                        report_mismatch("total_walked", 64'(seen.total), 64'(oldest.total));
                end
            end
            if (i_req_valid && i_req_ready) begin
                serve_command(i_req_cmd, i_req_data[15:0], i_req_data[16],
                              i_req_data[24:17], fresh);
                awaited.push_back(fresh);
            end
        end
        o_outstanding <= awaited.size();
    end

endmodule

/* verif/disk_request_scheduler_core_test.sv */
// Testbench top for disk_request_scheduler_core: directed and random command
// streams with random source and sink gaps; checking is done by drs_reply_checker.
// Depends on drs_pkg, drs_reply_checker and the RTL.
module disk_request_scheduler_core_test;
    import drs_pkg::*;

    localparam int IN_W        = 32;
    localparam int OUT_W       = 96;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 14;
    localparam int PHASE_WORDS = 80;
    localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [15:0]           i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int n_enqueue   = 0;
    int n_dispatch  = 0;
    int n_writes    = 0;
    bit src_lazy    = 1'b1;
    bit sink_lazy   = 1'b1;

    disk_request_scheduler_core uut (.*);

    drs_reply_checker watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_cmd    (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_status (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // sink: when lazy, either stalls straight away or waits for a word and then holds it
    initial begin
        int stall;
        bit hold;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = sink_lazy ? $urandom_range(0, 11) : 0;
            hold  = sink_lazy && ($urandom_range(0, 1) == 1);
            if (stall != 0 || hold) begin
                m_axis_tready <= 1'b0;
                if (hold)
                    do @(posedge i_clk); while (!m_axis_tvalid);
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [15:0] pick_block(input bit narrow);
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return 16'hFFFF;
        if (roll == 1)
            return 16'h0000;
        if (narrow)
            return 16'($urandom_range(0, 31));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(input logic cmd, input logic [15:0] blk, input logic wr,
                             input logic [7:0] tag);
        int gap;
        gap = src_lazy ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, tag, wr, blk};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_ENQUEUE)
            n_enqueue++;
        else
            n_dispatch++;
    endtask

    task automatic dispatch_one();
        send_word(CMD_DISPATCH, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_writes++;
    endtask

    // wait for every reply, then let the block fall idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0]         seed_blocks [16];
        logic [POLICY_W-1:0] pol;
        logic [15:0]         last;
        bit                  narrow;
        int                  enq_pct;
        int                  ph;
        int                  n;
        seed_blocks = '{16'd1000, 16'd0, 16'd65535, 16'd1000, 16'd40000, 16'd999,
                        16'd1001, 16'd65534, 16'd32768, 16'd5, 16'd12345, 16'd21845,
                        16'd43690, 16'd65535, 16'd1, 16'd50000};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_POLICY, 16'(POL_FCFS));
        write_reg(CFG_LAST_BLOCK, 16'hFFFF);
        dispatch_one();
        for (n = 0; n < 16; n++)
            send_word(CMD_ENQUEUE, seed_blocks[n], n[0], 8'(n * 17));
        send_word(CMD_ENQUEUE, 16'd7, 1'b1, 8'h80);
        dispatch_one();
        dispatch_one();
        settle();
        write_reg(CFG_POLICY, 16'(POL_UNUSED));
        dispatch_one();
        settle();
        write_reg(CFG_POLICY, 16'(POL_SSTF));
        dispatch_one();
        dispatch_one();
        settle();
        // head ends up above a last block of zero, so the wrap has no upward run
        write_reg(CFG_POLICY, 16'(POL_CSCAN));
        write_reg(CFG_LAST_BLOCK, 16'h0000);
        dispatch_one();
        dispatch_one();
        settle();
        write_reg(CFG_LAST_BLOCK, 16'hFFFF);
        repeat (3) dispatch_one();

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph % 5)
                0, 2:    pol = POL_CSCAN;
                1:       pol = POL_SSTF;
                3:       pol = POL_FCFS;
                default: pol = POL_UNUSED;
            endcase
            case (ph % 4)
                0:       last = 16'hFFFF;
                1:       last = 16'h0000;
                2:       last = 16'($urandom_range(0, 65535));
                default: last = 16'($urandom_range(0, 300));
            endcase
            write_reg(CFG_POLICY, 16'(pol));
            write_reg(CFG_LAST_BLOCK, last);
            src_lazy  = (ph % 3 != 1);
            sink_lazy = (ph % 4 != 2);
            narrow    = ph[0];
            enq_pct   = 35 + 15 * (ph % 3);
            for (n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(1, 100) <= enq_pct)
                    send_word(CMD_ENQUEUE, pick_block(narrow), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                else
                    dispatch_one();
            end
        end
        settle();

        $display("Ran %0d enqueue and %0d dispatch words across %0d register writes,",
                 n_enqueue, n_dispatch, n_writes);
        $display("covering full and empty queues, seek ties, scan wraps and stream stalls.");
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
